>>> design/priority_ready_queue_scheduler_assert.svh
// Assertion macros for the ready queue scheduler.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PRQS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PRQS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRQS_ASSERT_IMP(lbl, ante, cons, msg)
`define PRQS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/prqs_pkg.sv
`default_nettype none

package prqs_pkg;

    localparam int READY_DEPTH = 16;
    localparam int IDX_W       = $clog2(READY_DEPTH);
    localparam int CNT_W       = $clog2(READY_DEPTH + 1);

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_SCHED  = 2'd1;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [15:0] size;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic create;
        logic query;
        logic sched_empty;
        logic scan_init;
        logic scan;
        logic take;
        logic shift;
        logic append;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_create;
        logic is_sched;
        logic empty;
        logic scan_done;
        logic shift_done;
    } stat_t;

endpackage

`default_nettype wire

>>> design/prqs_ctrl.sv
`default_nettype none
`include "priority_ready_queue_scheduler_assert.svh"

module prqs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output logic                done,
    input  wire prqs_pkg::stat_t st,
    output prqs_pkg::cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_TAKE   = 7'b0001000,
        ST_SHIFT  = 7'b0010000,
        ST_APPEND = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (st.is_create)
                begin
                    cmd.create = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (st.is_sched)
                begin
                    if (st.empty)
                    begin
                        cmd.sched_empty = 1'b1;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
                else
                begin
                    cmd.query  = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_done)
                begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.shift_done)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESULT);

    `PRQS_ASSERT_NXT(a_no_early_result, start && !busy, !done, "result beat straight after accept")
    `PRQS_ASSERT_IMP(a_done_busy, done, busy, "result beat while idle")

endmodule

`default_nettype wire

>>> design/prqs_datapath.sv
`default_nettype none
`include "priority_ready_queue_scheduler_assert.svh"

module prqs_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire prqs_pkg::cmd_t              cmd,
    output prqs_pkg::stat_t                  st,
    input  wire logic [1:0]                  action,
    input  wire logic [15:0]                 new_pid,
    input  wire logic [7:0]                  new_priority,
    input  wire logic [15:0]                 new_size,
    output logic [1:0]                       status,
    output logic [15:0]                      running_pid,
    output logic [7:0]                       running_priority,
    output logic [15:0]                      running_size,
    output logic [prqs_pkg::CNT_W-1:0]       ready_total
);

    localparam int IDX_W = prqs_pkg::IDX_W;
    localparam int CNT_W = prqs_pkg::CNT_W;

    prqs_pkg::entry_t mem [prqs_pkg::READY_DEPTH];

    logic [1:0]       act_reg, act_next;
    prqs_pkg::entry_t new_reg, new_next;
    prqs_pkg::entry_t run_reg, run_next;
    logic             present_reg, present_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    prqs_pkg::entry_t best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             sh_vld_reg, sh_vld_next;
    logic [IDX_W-1:0] sh_idx_reg, sh_idx_next;
    prqs_pkg::entry_t old_reg, old_next;
    prqs_pkg::entry_t rd_data_reg;

    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    prqs_pkg::entry_t wr_data;

    assign full = (occ_reg >= CNT_W'(prqs_pkg::READY_DEPTH));

    assign st.is_create  = (act_reg == prqs_pkg::ACT_CREATE);
    assign st.is_sched   = (act_reg == prqs_pkg::ACT_SCHED);
    assign st.empty      = (occ_reg == '0);
    assign st.scan_done  = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == occ_reg - CNT_W'(1));
    assign st.shift_done = (rd_idx_reg >= occ_reg);

    always_comb
    begin
        act_next      = act_reg;
        new_next      = new_reg;
        run_next      = run_reg;
        present_next  = present_reg;
        occ_next      = occ_reg;
        status_next   = status_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        sh_vld_next   = 1'b0;
        sh_idx_next   = sh_idx_reg;
        old_next      = old_reg;
        wr_en         = 1'b0;
        wr_addr       = occ_reg[IDX_W-1:0];
        wr_data       = new_reg;

        if (cmd.accept)
        begin
            act_next      = action;
            new_next.pid  = new_pid;
            new_next.prio = new_priority;
            new_next.size = new_size;
        end

        if (cmd.create)
        begin
            if (full)
            begin
                status_next = prqs_pkg::STS_FULL;
            end
            else
            begin
                status_next = prqs_pkg::STS_OK;
                if (!present_reg)
                begin
                    run_next     = new_reg;
                    present_next = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
        end

        if (cmd.query)
        begin
            status_next = prqs_pkg::STS_OK;
        end

        if (cmd.sched_empty)
        begin
            status_next = prqs_pkg::STS_EMPTY;
        end

        if (cmd.scan_init)
        begin
            rd_idx_next = '0;
        end

        // read of rd_idx in flight, compare on the entry read in the previous cycle
        if (cmd.scan)
        begin
            rd_idx_next  = rd_idx_reg + CNT_W'(1);
            cmp_vld_next = (rd_idx_reg < occ_reg);
            cmp_idx_next = rd_idx_reg[IDX_W-1:0];
            if (cmp_vld_reg && ((cmp_idx_reg == '0) || (rd_data_reg.prio < best_reg.prio)))
            begin
                best_next     = rd_data_reg;
                best_idx_next = cmp_idx_reg;
            end
        end

        if (cmd.take)
        begin
            old_next     = run_reg;
            run_next     = best_reg;
            present_next = 1'b1;
            rd_idx_next  = CNT_W'(best_idx_reg) + CNT_W'(1);
        end

        // read k+1, write it to k on the next cycle
        if (cmd.shift)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            sh_vld_next = (rd_idx_reg < occ_reg);
            sh_idx_next = IDX_W'(rd_idx_reg - CNT_W'(1));
            if (sh_vld_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = sh_idx_reg;
                wr_data = rd_data_reg;
            end
        end

        if (cmd.append)
        begin
            status_next = prqs_pkg::STS_OK;
            wr_en       = 1'b1;
            wr_addr     = IDX_W'(occ_reg - CNT_W'(1));
            wr_data     = old_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            present_reg <= 1'b0;
            occ_reg     <= '0;
            status_reg  <= prqs_pkg::STS_OK;
            cmp_vld_reg <= 1'b0;
            sh_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            run_reg     <= run_next;
            present_reg <= present_next;
            occ_reg     <= occ_next;
            status_reg  <= status_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_vld_reg  <= sh_vld_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        new_reg      <= new_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        sh_idx_reg   <= sh_idx_next;
        old_reg      <= old_next;
    end

    assign status           = status_reg;
    assign running_pid      = run_reg.pid;
    assign running_priority = run_reg.prio;
    assign running_size     = run_reg.size;
    assign ready_total      = occ_reg;

    `PRQS_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= CNT_W'(prqs_pkg::READY_DEPTH), "occ past depth")
    `PRQS_ASSERT_IMP(a_append_nonempty, cmd.append, occ_reg != '0, "append into empty table")
    `PRQS_ASSERT_IMP(a_take_present, cmd.scan_init, present_reg, "scan with no running process")

endmodule

`default_nettype wire

>>> design/priority_ready_queue_scheduler.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------------
// command  | start, busy         | action, new_pid, new_priority, new_size
// result   | done (1-cycle beat) | status, running_pid, running_priority, running_size,
//          |                     | ready_total
//
// Create, query and a schedule on an empty table: accept, decode, then the result beat.
// Schedule (N ready entries, b index of the winner): accept, decode, a scan through the
// single read port, take, a shift of the entries past b, one write a cycle, then append and the result beat.
// One item in flight at a time; busy stays high until the result beat ends.
// Reset is asynchronous, active low; the table needs no clearing pass.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none

module priority_ready_queue_scheduler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   action,
    input  wire logic [15:0]                  new_pid,
    input  wire logic [7:0]                   new_priority,
    input  wire logic [15:0]                  new_size,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [15:0]                       running_pid,
    output logic [7:0]                        running_priority,
    output logic [15:0]                       running_size,
    output logic [prqs_pkg::CNT_W-1:0]        ready_total
);

    prqs_pkg::cmd_t  cmd;
    prqs_pkg::stat_t st;

    prqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .st    (st),
        .cmd   (cmd)
    );

    prqs_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .action           (action),
        .new_pid          (new_pid),
        .new_priority     (new_priority),
        .new_size         (new_size),
        .status           (status),
        .running_pid      (running_pid),
        .running_priority (running_priority),
        .running_size     (running_size),
        .ready_total      (ready_total)
    );

endmodule

`default_nettype wire
